// ----- hdl/kwt_pkg.sv -----
// Shared types, codes and character-class helpers for the keyword tokenizer.
package kwt_pkg;

    typedef enum logic [4:0] {
        KIND_END     = 5'd0,
        KIND_IDENT   = 5'd1,
        KIND_INT     = 5'd2,
        KIND_RETURN  = 5'd3,
        KIND_FUN     = 5'd4,
        KIND_VAR     = 5'd5,
        KIND_IF      = 5'd6,
        KIND_LPAREN  = 5'd7,
        KIND_RPAREN  = 5'd8,
        KIND_LBRACE  = 5'd9,
        KIND_RBRACE  = 5'd10,
        KIND_ASSIGN  = 5'd11,
        KIND_SEMI    = 5'd12,
        KIND_PLUS    = 5'd13,
        KIND_MINUS   = 5'd14,
        KIND_STAR    = 5'd15,
        KIND_SLASH   = 5'd16,
        KIND_COMMA   = 5'd17,
        KIND_UNKNOWN = 5'd18
    } t_kind;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_IDENT = 2'd1,
        RUN_INT   = 2'd2
    } t_run;

    typedef struct packed {
        logic [7:0]  token_char;
        logic [15:0] token_length;
        logic [15:0] token_start;
        t_kind       token_kind;
    } t_token;

    // One accepted byte yields at most two tokens; a bundle holds one or two.
    typedef struct packed {
        logic   two;
        t_token tok1;
        t_token tok0;
    } t_bundle;

    localparam int unsigned KwBytes = 6;

    // Keyword text, first character in byte 0, zero padded.
    localparam logic [KwBytes-1:0][7:0] KwReturn = {"n", "r", "u", "t", "e", "r"};
    localparam logic [KwBytes-1:0][7:0] KwFun    = {8'h00, 8'h00, 8'h00, "n", "u", "f"};
    localparam logic [KwBytes-1:0][7:0] KwVar    = {8'h00, 8'h00, 8'h00, "r", "a", "v"};
    localparam logic [KwBytes-1:0][7:0] KwIf     = {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "=":     k = KIND_ASSIGN;
            ";":     k = KIND_SEMI;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            ",":     k = KIND_COMMA;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Window bytes past the run length are always zero, so a full compare works.
    function automatic t_kind run_token_kind(input t_run rk, input logic [15:0] len,
                                             input logic [KwBytes-1:0][7:0] w);
        t_kind k;
        if (rk == RUN_INT) begin
            k = KIND_INT;
        end else if (len == 16'd6 && w == KwReturn) begin
            k = KIND_RETURN;
        end else if (len == 16'd3 && w == KwFun) begin
            k = KIND_FUN;
        end else if (len == 16'd3 && w == KwVar) begin
            k = KIND_VAR;
        end else if (len == 16'd2 && w == KwIf) begin
            k = KIND_IF;
        end else begin
            k = KIND_IDENT;
        end
        return k;
    endfunction

endpackage

// ----- hdl/kwt_lexer.sv -----
// Run tracking and token generation for one registered source byte per cycle, on each fire.
module kwt_lexer #(
    parameter longint unsigned MAX_SOURCE_BYTES     = 65536,
    parameter int unsigned     KEYWORD_WINDOW_BYTES = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic             i_final,
    output logic             o_push,
    output kwt_pkg::t_bundle o_bundle
);
    import kwt_pkg::*;

    localparam longint unsigned PosMax   = MAX_SOURCE_BYTES - 1;
    localparam logic [15:0]     PosLimit = (PosMax < 64'd65535) ? PosMax[15:0] : 16'hFFFF;

    t_run                                r_run_kind,  n_run_kind;
    logic [15:0]                         r_run_start, n_run_start;
    logic [15:0]                         r_run_len,   n_run_len;
    logic [KEYWORD_WINDOW_BYTES-1:0][7:0] r_window,   n_window;
    logic [15:0]                         r_pos,       n_pos;
    logic                                r_ended,     n_ended;

    t_token     cand     [4];
    logic [3:0] cand_v;
    logic       goes_on;
    logic [1:0] n_tok;

    always_comb begin
        n_run_kind  = r_run_kind;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_window    = r_window;
        n_pos       = r_pos;
        n_ended     = r_ended;
        cand_v      = '0;
        goes_on     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            cand[i] = '0;
        end

        // closing the run that is open before this byte
        cand[0].token_kind   = run_token_kind(r_run_kind, r_run_len, r_window[KwBytes-1:0]);
        cand[0].token_start  = r_run_start;
        cand[0].token_length = r_run_len;

        if (!r_ended) begin
            if (i_byte == 8'd0) begin
                cand_v[0]          = (r_run_kind != RUN_NONE);
                cand_v[3]          = 1'b1;
                cand[3].token_kind = KIND_END;
                cand[3].token_start = r_pos;
                n_run_kind = RUN_NONE;
                n_run_len  = '0;
                n_ended    = 1'b1;
            end else begin
                goes_on = (r_run_kind == RUN_IDENT &&
                           (is_alpha(i_byte) || is_digit(i_byte) || i_byte == "_")) ||
                          (r_run_kind == RUN_INT && is_digit(i_byte));
                if (goes_on) begin
                    for (int i = 0; i < KEYWORD_WINDOW_BYTES; i++) begin
                        if (r_run_len == 16'(i)) n_window[i] = i_byte;
                    end
                    if (r_run_len != 16'hFFFF) n_run_len = r_run_len + 16'd1;
                end else begin
                    cand_v[0]  = (r_run_kind != RUN_NONE);
                    n_run_kind = RUN_NONE;
                    n_run_len  = '0;
                    if (is_alpha(i_byte) || is_digit(i_byte)) begin
                        n_run_kind  = is_alpha(i_byte) ? RUN_IDENT : RUN_INT;
                        n_run_start = r_pos;
                        n_run_len   = 16'd1;
                        n_window    = '0;
                        n_window[0] = i_byte;
                    end else if (!is_space(i_byte)) begin
                        cand_v[1]            = 1'b1;
                        cand[1].token_kind   = punct_kind(i_byte);
                        cand[1].token_start  = r_pos;
                        cand[1].token_length = 16'd1;
                        cand[1].token_char   = i_byte;
                    end
                end
                if (r_pos < PosLimit) n_pos = r_pos + 16'd1;
                if (i_final) begin
                    // run still open after this byte, then the end token
                    cand_v[2]            = (n_run_kind != RUN_NONE);
                    cand[2].token_kind   = run_token_kind(n_run_kind, n_run_len,
                                                          n_window[KwBytes-1:0]);
                    cand[2].token_start  = n_run_start;
                    cand[2].token_length = n_run_len;
                    cand_v[3]            = 1'b1;
                    cand[3].token_kind   = KIND_END;
                    cand[3].token_start  = n_pos;
                end
            end
        end

        if (i_final) begin
            n_run_kind  = RUN_NONE;
            n_run_start = '0;
            n_run_len   = '0;
            n_window    = '0;
            n_pos       = '0;
            n_ended     = 1'b0;
        end
    end

    // keep the first two candidates in order; a third is dropped
    always_comb begin
        o_bundle = '0;
        n_tok    = '0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i]) begin
                if (n_tok == 2'd0) begin
                    o_bundle.tok0 = cand[i];
                    n_tok         = 2'd1;
                end else if (n_tok == 2'd1) begin
                    o_bundle.tok1 = cand[i];
                    o_bundle.two  = 1'b1;
                    n_tok         = 2'd2;
                end
            end
        end
        o_push = i_fire && (n_tok != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_kind  <= RUN_NONE;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_window    <= '0;
            r_pos       <= '0;
            r_ended     <= 1'b0;
        end else if (i_fire) begin
            r_run_kind  <= n_run_kind;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
            r_window    <= n_window;
            r_pos       <= n_pos;
            r_ended     <= n_ended;
        end
    end

endmodule

// ----- hdl/kwt_result_queue.sv -----
// Two-entry queue of token bundles, unloaded one token per beat.
module kwt_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kwt_pkg::t_bundle i_bundle,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output kwt_pkg::t_token  o_token,
    output logic             o_last
);
    import kwt_pkg::*;

    t_bundle    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       r_sub;
    t_bundle    head;
    logic       beat;
    logic       pop;

    assign head    = r_mem[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_token = r_sub ? head.tok1 : head.tok0;
    assign o_last  = !head.two || r_sub;
    assign beat    = o_valid && i_ready;
    assign pop     = beat && o_last;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) n_count = r_count + 2'd1;
        if (!i_push && pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (pop) r_rd_ptr <= !r_rd_ptr;
            if (beat) r_sub <= !o_last;
        end
    end

endmodule

// ----- hdl/keyword_tokenizer.sv -----
// Top level of the byte-serial keyword tokenizer.
//
// Source text streams in one byte per beat (tlast marks the final byte of a
// source) and tokens stream out one per beat, tlast on the last token caused
// by a byte and tuser carrying the token kind. Each accepted byte is held in
// an input register, then classified and run-tracked, and its tokens (one
// or two) go to a two-entry result queue as one bundle. While the output
// is ready, the block sustains one byte per cycle for bytes giving one token
// or none; a byte giving two tokens takes two output beats, set by the
// single-token-wide output port. Tokens pass the input register, then the
// result queue. There is no configuration and no clearing pass after reset.
module keyword_tokenizer #(
    parameter longint unsigned MAX_SOURCE_BYTES     = 65536,
    parameter int unsigned     KEYWORD_WINDOW_BYTES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] source_byte
    input  logic        i_s_tlast,   // final_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [15:0] token_start, [31:16] token_length,
                                     // [39:32] token_char
    output logic [4:0]  o_m_tuser,   // [4:0] token_kind
    output logic        o_m_tlast    // last_of_run
);
    import kwt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;
    logic       room;
    logic       fire;
    logic       push;
    t_bundle    bundle;
    t_token     token;

    // an item leaves the input register when the queue can take a bundle
    assign fire       = r_in_valid && room;
    assign o_s_tready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_final <= i_s_tlast;
        end
    end

    kwt_lexer #(
        .MAX_SOURCE_BYTES     (MAX_SOURCE_BYTES),
        .KEYWORD_WINDOW_BYTES (KEYWORD_WINDOW_BYTES)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .i_final  (r_in_final),
        .o_push   (push),
        .o_bundle (bundle)
    );

    kwt_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_token  (token),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {token.token_char, token.token_length, token.token_start};
    assign o_m_tuser = token.token_kind;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for keyword_tokenizer: byte streams in, tokens checked against a predictor.
module tb_top;
    import kwt_pkg::*;

    // Cycles with no beat on either side before the run is declared hung. The longest
    // legal quiet stretch is the long receiver hold-off plus a few idle bursts.
    localparam int unsigned IdleLimit   = 2000;
    // Quiet cycles after the last expected token, to catch stray extra beats.
    localparam int unsigned DrainCycles = 16;
    localparam int unsigned RandomBytes = 1520;
    localparam int unsigned HoldAfter   = 300;  // tokens seen before the long hold-off
    localparam int unsigned HoldCycles  = 300;
    localparam logic [15:0] PosCap      = 16'hFFFF;

    typedef struct {
        logic [7:0] ch;
        logic       is_last;
    } t_src_beat;

    typedef struct {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [7:0]  ch;
        logic        is_last;
    } t_tok_exp;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;  // [7:0] source_byte
    logic        i_s_tlast  = 1'b0;   // final_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;           // [15:0] start, [31:16] length, [39:32] char
    logic [4:0]  o_m_tuser;           // [4:0] kind
    logic        o_m_tlast;           // last token caused by a byte

    keyword_tokenizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus store and source-text builders
    // ------------------------------------------------------------------
    t_src_beat   src_pending[$];

    task automatic add_byte(input logic [7:0] c, input logic fin);
        t_src_beat b;
        b.ch      = c;
        b.is_last = fin;
        src_pending.push_back(b);
    endtask

    task automatic add_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], fin && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] letter_pick();
        if ($urandom_range(0, 1) != 0) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    // Anything that may continue an identifier.
    function automatic logic [7:0] word_pick();
        int unsigned p;
        p = $urandom_range(0, 9);
        if (p < 6) return letter_pick();
        if (p < 9) return 8'("0" + $urandom_range(0, 9));
        return "_";
    endfunction

    function automatic logic [7:0] blank_pick();
        if ($urandom_range(0, 5) == 0) return " ";
        return 8'(9 + $urandom_range(0, 4));  // tab, LF, VT, FF, CR
    endfunction

    // One lexeme of plausible source: mostly keywords, names, numbers and symbols.
    task automatic add_lexeme();
        string       words[4] = '{"return", "fun", "var", "if"};
        string       marks    = "(){}=;+-*/,";
        string       oddities = "!#$%&.:<>?@[]^|~`'";
        string       w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            add_text(words[$urandom_range(0, 3)], 1'b0);
        end else if (pick < 30) begin
            // near misses: longer, shorter or capitalized keywords
            w = words[$urandom_range(0, 3)];
            case ($urandom_range(0, 2))
                0: w = $sformatf("%s%c", w, word_pick());
                1: w = w.substr(0, w.len() - 2);
                default: w = $sformatf("%c%s", 8'(w[0] - 8'd32), w.substr(1, w.len() - 1));
            endcase
            add_text(w, 1'b0);
        end else if (pick < 50) begin
            add_byte(letter_pick(), 1'b0);
            repeat ($urandom_range(0, 7)) add_byte(word_pick(), 1'b0);
        end else if (pick < 62) begin
            repeat ($urandom_range(1, 6)) add_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        end else if (pick < 90) begin
            add_byte(marks[$urandom_range(0, 10)], 1'b0);
        end else if (pick < 94) begin
            add_byte("_", 1'b0);
        end else if (pick < 97) begin
            add_byte(8'($urandom_range(128, 255)), 1'b0);
        end else begin
            add_byte(oddities[$urandom_range(0, oddities.len() - 1)], 1'b0);
        end
    endtask

    // A well-formed source, closed by a final byte, by a zero, or by a zero followed
    // by ignored junk and a final flag.
    task automatic add_program();
        t_src_beat   tail;
        int unsigned pick;
        repeat ($urandom_range(1, 12)) begin
            add_lexeme();
            if ($urandom_range(0, 1) != 0) repeat ($urandom_range(1, 2)) add_byte(blank_pick(), 1'b0);
        end
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            tail = src_pending.pop_back();
            tail.is_last = 1'b1;
            src_pending.push_back(tail);
        end else if (pick < 16) begin
            add_byte(8'h00, 1'b0);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
            add_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            add_byte(8'h00, 1'b1);
        end
    endtask

    // Raw bytes with a sprinkling of final flags.
    task automatic add_noise();
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        add_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Source driver: presents queued bytes, idling in random bursts
    // ------------------------------------------------------------------
    t_src_beat   src_cur;
    int unsigned src_gap  = 0;
    int unsigned src_sent = 0;
    logic        quiet_end = 1'b0;  // set near the end of the stimulus: no idling from then on

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (src_gap != 0) begin
                src_gap--;
                i_s_tvalid <= 1'b0;
            end else if (src_pending.size() != 0) begin
                src_cur = src_pending.pop_front();
                src_sent++;
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= src_cur.ch;
                i_s_tlast  <= src_cur.is_last;
                // every third stretch of 300 bytes runs without gaps
                if (!quiet_end && (src_sent / 300) % 3 != 2 && $urandom_range(0, 15) == 0)
                    src_gap = $urandom_range(1, 16);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        quiet_end <= src_pending.size() < 200;
    end

    // ------------------------------------------------------------------
    // Token sink: random stalls plus one long hold-off that backs the block up
    // ------------------------------------------------------------------
    int unsigned tok_seen   = 0;
    int unsigned sink_stall = 0;
    int unsigned sink_hold  = 0;
    logic        hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) tok_seen++;
            if (sink_hold != 0) begin
                sink_hold--;
                i_m_tready <= 1'b0;
            end else if (!hold_done && tok_seen >= HoldAfter) begin
                hold_done = 1'b1;
                sink_hold = HoldCycles - 1;
                i_m_tready <= 1'b0;
            end else if (sink_stall != 0) begin
                sink_stall--;
                i_m_tready <= 1'b0;
            end else if (!quiet_end && (tok_seen / 200) % 3 != 1 && $urandom_range(0, 15) == 0) begin
                sink_stall = $urandom_range(0, 15);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    t_tok_exp    tok_due[$];   // tokens still to come, oldest first
    t_tok_exp    lx_out[$];    // tokens produced by the byte in hand
    t_run        lx_run   = RUN_NONE;
    logic [15:0] lx_start = '0;
    logic [15:0] lx_len   = '0;
    logic [15:0] lx_pos   = '0;
    string       lx_head  = "";    // first six bytes of the open run
    logic        lx_done  = 1'b0;  // zero byte seen, waiting for the final flag

    function automatic logic letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank_ch(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic t_kind sym_kind(input logic [7:0] c);
        string marks = "(){}=;+-*/,";
        for (int k = 0; k < marks.len(); k++)
            if (marks[k] == c) return t_kind'(KIND_LPAREN + k);
        return KIND_UNKNOWN;
    endfunction

    function automatic t_kind word_kind();
        if (lx_run == RUN_INT) return KIND_INT;
        if (lx_len == 16'd6 && lx_head == "return") return KIND_RETURN;
        if (lx_len == 16'd3 && lx_head == "fun") return KIND_FUN;
        if (lx_len == 16'd3 && lx_head == "var") return KIND_VAR;
        if (lx_len == 16'd2 && lx_head == "if") return KIND_IF;
        return KIND_IDENT;
    endfunction

    task automatic emit(input t_kind k, input logic [15:0] s, input logic [15:0] n,
                        input logic [7:0] c);
        t_tok_exp t;
        t.kind    = k;
        t.start   = s;
        t.len     = n;
        t.ch      = c;
        t.is_last = 1'b0;
        lx_out.push_back(t);
    endtask

    task automatic lex_clear();
        lx_run   = RUN_NONE;
        lx_start = '0;
        lx_len   = '0;
        lx_pos   = '0;
        lx_head  = "";
        lx_done  = 1'b0;
    endtask

    task automatic lex_close();
        if (lx_run != RUN_NONE) begin
            emit(word_kind(), lx_start, lx_len, 8'h00);
            lx_run = RUN_NONE;
            lx_len = '0;
        end
    endtask

    task automatic lex_open(input t_run k);
        lx_run   = k;
        lx_start = lx_pos;
        lx_len   = '0;
        lx_head  = "";
    endtask

    task automatic lex_extend(input logic [7:0] c);
        if (lx_len < 16'd6) lx_head = $sformatf("%s%c", lx_head, c);
        if (lx_len != PosCap) lx_len++;
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic fin);
        logic        grows;
        logic [15:0] end_at;
        t_tok_exp    t;
        lx_out.delete();
        if (lx_done) begin
            // junk after a zero byte: silent, the final flag restarts the source
            if (fin) lex_clear();
            return;
        end
        if (c == 8'h00) begin
            lex_close();
            emit(KIND_END, lx_pos, 16'd0, 8'h00);
            if (fin) lex_clear();
            else lx_done = 1'b1;
        end else begin
            grows = (lx_run == RUN_IDENT && (letter_ch(c) || digit_ch(c) || c == "_")) ||
                    (lx_run == RUN_INT && digit_ch(c));
            if (grows) begin
                lex_extend(c);
            end else begin
                lex_close();
                if (letter_ch(c)) begin
                    lex_open(RUN_IDENT);
                    lex_extend(c);
                end else if (digit_ch(c)) begin
                    lex_open(RUN_INT);
                    lex_extend(c);
                end else if (!blank_ch(c)) begin
                    emit(sym_kind(c), lx_pos, 16'd1, c);
                end
            end
            if (lx_pos != PosCap) lx_pos++;
            if (fin) begin
                // end token sits one past the final byte
                end_at = lx_pos;
                lex_close();
                emit(KIND_END, end_at, 16'd0, 8'h00);
                lex_clear();
            end
        end
        // only two tokens leave per byte; a third (always the end token) is lost
        while (lx_out.size() > 2) void'(lx_out.pop_back());
        if (lx_out.size() != 0) begin
            t = lx_out.pop_back();
            t.is_last = 1'b1;
            lx_out.push_back(t);
        end
        foreach (lx_out[i]) tok_due.push_back(lx_out[i]);
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on each byte beat, checks each token beat
    // ------------------------------------------------------------------
    int unsigned fault_count = 0;

    function automatic string show(input t_tok_exp t);
        return $sformatf("kind %0d start %0d len %0d char 0x%02h last %0b",
                         t.kind, t.start, t.len, t.ch, t.is_last);
    endfunction

    task automatic check_token();
        t_tok_exp seen;
        t_tok_exp want;
        seen.kind    = t_kind'(o_m_tuser);
        seen.start   = o_m_tdata[15:0];
        seen.len     = o_m_tdata[31:16];
        seen.ch      = o_m_tdata[39:32];
        seen.is_last = o_m_tlast;
        if (tok_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("mismatch: no token expected, got %s", show(seen));
        end else begin
            want = tok_due.pop_front();
            if (seen.kind !== want.kind || seen.start !== want.start || seen.len !== want.len ||
                seen.ch !== want.ch || seen.is_last !== want.is_last) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("mismatch: expected %s, got %s", show(want), show(seen));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) lex_byte(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) check_token();
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any beat means the block is stuck
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned base;

        // directed: keyword and symbol tokens, leading underscore, run closed at a final byte
        add_text("if(_x9)", 1'b1);
        // zero ends the text inside a run; later bytes are ignored until the final flag
        add_text("ab1", 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h00, 1'b1);
        // final letter closes an integer and opens a run of its own
        add_text("9a", 1'b1);
        add_text("var;", 1'b1);
        add_byte(8'hFF, 1'b1);   // high byte alone
        add_byte(" ", 1'b1);     // blank-only source
        add_byte(8'h00, 1'b1);   // empty source

        base = src_pending.size();
        while (src_pending.size() - base < RandomBytes) begin
            if ($urandom_range(0, 9) == 0) add_noise();
            else add_program();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (src_pending.size() != 0 || i_s_tvalid);
        do @(negedge i_clk); while (tok_due.size() != 0);
        repeat (DrainCycles) @(negedge i_clk);

        if (fault_count == 0 && tok_due.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
